// ===== hdl/rvex_pkg.sv =====
// ----------------------------------------------------------------------------
// rvex_pkg
// Types and codes shared by the RV32I execute unit: instruction classes,
// funct3 codes, result actions and the transaction payload structs.
// ----------------------------------------------------------------------------
package rvex_pkg;

  localparam int unsigned XLEN = 32;
  localparam logic [XLEN-1:0] LINK_OFFSET = 32'd4;

  typedef enum logic [3:0] {
    FUNC_HALT   = 4'd0,
    FUNC_BRANCH = 4'd1,
    FUNC_JAL    = 4'd2,
    FUNC_LUI    = 4'd3,
    FUNC_AUIPC  = 4'd4,
    FUNC_STORE  = 4'd5,
    FUNC_LOAD   = 4'd6,
    FUNC_OP_IMM = 4'd7,
    FUNC_JALR   = 4'd8,
    FUNC_OP     = 4'd9
  } func_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_LOAD  = 3'd2,
    ACT_STORE = 3'd3,
    ACT_HALT  = 3'd4
  } action_t;

  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_SLT  = 3'b010;
  localparam logic [2:0] F3_SLTU = 3'b011;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;

  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;
  localparam logic [2:0] F3_BLT  = 3'b100;
  localparam logic [2:0] F3_BGE  = 3'b101;
  localparam logic [2:0] F3_BLTU = 3'b110;
  localparam logic [2:0] F3_BGEU = 3'b111;

  localparam logic [2:0] F3_BYTE  = 3'b000;
  localparam logic [2:0] F3_HALF  = 3'b001;
  localparam logic [2:0] F3_WORD  = 3'b010;
  localparam logic [2:0] F3_BYTEU = 3'b100;
  localparam logic [2:0] F3_HALFU = 3'b101;

  localparam logic [4:0] SHAMT_MASK = 5'b11111;

  typedef struct packed {
    logic [3:0]         func;
    logic [2:0]         funct3;
    logic               alt_function;
    logic [XLEN-1:0]    source_a;
    logic [XLEN-1:0]    source_b;
    logic signed [XLEN-1:0] immediate;
    logic [XLEN-1:0]    instr_pc;
    logic [4:0]         dest_index;
  } instr_t;

  typedef struct packed {
    logic [2:0]      action;
    logic [4:0]      write_index;
    logic [XLEN-1:0] write_value;
    logic            redirect;
    logic [XLEN-1:0] redirect_target;
    logic [XLEN-1:0] mem_address;
    logic [XLEN-1:0] store_data;
    logic [1:0]      access_size;
    logic            load_signed;
  } result_t;

endpackage

// ===== hdl/rv32i_execute_unit.sv =====
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// Execute stage of an RV32I core: ALU, branch resolution, jump link and
// load/store address generation for one decoded instruction per transaction.
// ----------------------------------------------------------------------------
// The instr channel carries one decoded instruction per transaction and the
// result channel returns exactly one result for each, in order. Both use
// valid and stall; a transaction completes on a rising edge with valid high
// and stall low.
// An accepted instruction is held in an input register, evaluated by a single
// combinational pass (adder, comparator, shifter and result mux) and captured
// in a result register. The throughput is one instruction per cycle while
// result_stall is low.
// While the receiver stalls, the result register holds its transaction and
// the input register fills; instr_stall rises only when both are occupied and
// result_stall is high. The synchronous reset empties both registers.
// ----------------------------------------------------------------------------
module rv32i_execute_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              instr_valid,
  output logic              instr_stall,
  input  rvex_pkg::instr_t  instr,
  output logic              result_valid,
  input  logic              result_stall,
  output rvex_pkg::result_t result
);
  import rvex_pkg::*;

  logic            held_valid;
  instr_t          held;
  logic            out_valid;
  result_t         out_data;
  logic            out_ready;
  result_t         eval_next;

  logic [XLEN-1:0] op_b;
  logic [XLEN-1:0] sum_ab;
  logic [XLEN-1:0] sum_a_imm;
  logic [XLEN-1:0] pc_imm;
  logic [XLEN-1:0] alu_value;
  logic [4:0]      shamt;
  logic            lt_signed;
  logic            lt_unsigned;
  logic            equal;
  logic            taken;

  assign out_ready   = !out_valid || !result_stall;
  assign instr_stall = held_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!instr_stall) begin
        held_valid <= instr_valid;
      end
      if (out_ready) begin
        out_valid <= held_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!instr_stall && instr_valid) begin
      held <= instr;
    end
    if (out_ready && held_valid) begin
      out_data <= eval_next;
    end
  end

  assign op_b        = (held.func == FUNC_OP || held.func == FUNC_BRANCH) ? held.source_b
                                                                           : held.immediate;
  assign shamt       = op_b[4:0] & SHAMT_MASK;
  assign sum_a_imm   = held.source_a + held.immediate;
  assign pc_imm      = held.instr_pc + held.immediate;
  assign lt_signed   = $signed(held.source_a) < $signed(op_b);
  assign lt_unsigned = held.source_a < op_b;
  assign equal       = held.source_a == op_b;

  always_comb begin
    sum_ab = held.source_a + op_b;
    unique case (held.funct3)
      F3_ADD: begin
        if (held.func == FUNC_OP && held.alt_function) begin
          sum_ab = held.source_a - op_b;
        end
        alu_value = sum_ab;
      end
      F3_SLL:  alu_value = held.source_a << shamt;
      F3_SLT:  alu_value = {{(XLEN-1){1'b0}}, lt_signed};
      F3_SLTU: alu_value = {{(XLEN-1){1'b0}}, lt_unsigned};
      F3_XOR:  alu_value = held.source_a ^ op_b;
      F3_SR: begin
        if (held.alt_function) begin
          alu_value = $unsigned($signed(held.source_a) >>> shamt);
        end else begin
          alu_value = held.source_a >> shamt;
        end
      end
      F3_OR:   alu_value = held.source_a | op_b;
      default: alu_value = held.source_a & op_b;
    endcase
  end

  always_comb begin
    unique case (held.funct3)
      F3_BEQ:  taken = equal;
      F3_BNE:  taken = !equal;
      F3_BLT:  taken = lt_signed;
      F3_BGE:  taken = !lt_signed;
      F3_BLTU: taken = lt_unsigned;
      F3_BGEU: taken = !lt_unsigned;
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    eval_next = '0;
    unique case (held.func)
      FUNC_HALT: eval_next.action = ACT_HALT;
      FUNC_BRANCH: begin
        if (taken) begin
          eval_next.redirect        = 1'b1;
          eval_next.redirect_target = pc_imm;
        end
      end
      FUNC_JAL: begin
        eval_next.action          = ACT_WRITE;
        eval_next.write_index     = held.dest_index;
        eval_next.write_value     = held.instr_pc + LINK_OFFSET;
        eval_next.redirect        = 1'b1;
        eval_next.redirect_target = pc_imm;
      end
      FUNC_LUI: begin
        eval_next.action      = ACT_WRITE;
        eval_next.write_index = held.dest_index;
        eval_next.write_value = held.immediate;
      end
      FUNC_AUIPC: begin
        eval_next.action      = ACT_WRITE;
        eval_next.write_index = held.dest_index;
        eval_next.write_value = pc_imm;
      end
      FUNC_STORE: begin
        if (held.funct3 == F3_BYTE || held.funct3 == F3_HALF
            || held.funct3 == F3_WORD) begin
          eval_next.action      = ACT_STORE;
          eval_next.mem_address = sum_a_imm;
          eval_next.store_data  = held.source_b;
          eval_next.access_size = held.funct3[1:0];
        end
      end
      FUNC_LOAD: begin
        if (held.funct3 == F3_BYTE || held.funct3 == F3_HALF
            || held.funct3 == F3_WORD || held.funct3 == F3_BYTEU
            || held.funct3 == F3_HALFU) begin
          eval_next.action      = ACT_LOAD;
          eval_next.write_index = held.dest_index;
          eval_next.mem_address = sum_a_imm;
          eval_next.access_size = held.funct3[1:0];
          eval_next.load_signed = (held.funct3 == F3_BYTE || held.funct3 == F3_HALF);
        end
      end
      FUNC_OP_IMM, FUNC_OP: begin
        eval_next.action      = ACT_WRITE;
        eval_next.write_index = held.dest_index;
        eval_next.write_value = alu_value;
      end
      FUNC_JALR: begin
        eval_next.action          = ACT_WRITE;
        eval_next.write_index     = held.dest_index;
        eval_next.write_value     = held.instr_pc + LINK_OFFSET;
        eval_next.redirect        = 1'b1;
        eval_next.redirect_target = {sum_a_imm[XLEN-1:1], 1'b0};
      end
      default: eval_next = '0;
    endcase
  end

  assign result_valid = out_valid;
  assign result       = out_data;

endmodule
